/* sv/gqi_pkg.sv */
// shared constants and lookup functions for the gyro quaternion integrator
`default_nettype none
package gqi_pkg;

  // cordic setup
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

  // half turn per rate unit: 360 deg * 2 * 1e9 ns = 2^13 * PH_DIV,
  // so the phase is (mag * dt * 8) / PH_DIV
  localparam logic [26:0] PH_DIV = 27'd87890625;
  // reciprocal of PH_DIV scaled by 2^58
  localparam logic [31:0] PH_RECIP = 32'((64'd1 << 58) / 64'd87890625);

  // arctangent table as a binary angle, 2^32 per turn
  function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;
      5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;
      5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;
      5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // sign of each hamilton product term: output part o, orientation part t
  function automatic logic ham_neg(input logic [1:0] o, input logic [1:0] t);
    logic n;
    case (o)
      2'd0: n = (t != 2'd0);
      2'd1: n = (t == 2'd3);
      2'd2: n = (t == 2'd1);
      2'd3: n = (t == 2'd2);
      default: n = 1'b0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* sv/gyro_quaternion_integrator.sv */
// gyro quaternion integrator top level: sequencer around shared multiplier and divider
// One transaction at a time. After an input is accepted the block runs a
// sequence: three squares through the shared 33x33 multiplier, a 32-step
// bit-serial square root, a threshold compare, then for a moving sample the
// angle product and its division by the half-turn constant as two quotient
// digits, each a reciprocal multiply, a back multiply and one correction on the
// shared multiplier, three axis divisions on the shared restoring divider
// (skipped when the rate magnitude is zero), 30 cordic steps, and 19
// multiply/accumulate pairs for the axis scaling and the hamilton product. A
// sample below the motion threshold goes straight to the result. The result
// is held until out_ready. in_ready is high only while the block is idle and
// no result is pending.
`default_nettype none
module gyro_quaternion_integrator #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [30:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_rate_pitch,
  input  wire logic signed [31:0] in_rate_roll,
  input  wire logic signed [31:0] in_rate_yaw,
  input  wire logic [29:0]        in_interval_ns,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_quat_w,
  output logic signed [31:0]      out_quat_x,
  output logic signed [31:0]      out_quat_y,
  output logic signed [31:0]      out_quat_z,
  output logic                    out_updated
);
  import gqi_pkg::*;

  localparam int F = QUAT_FRAC_BITS;
  localparam int SH = 30 - F;
  localparam logic signed [31:0] ONE = 32'sd1 <<< F;
  localparam logic signed [65:0] ONE66 = 66'sd1 <<< F;
  localparam logic signed [65:0] RND_F = 66'sd1 <<< (F - 1);
  localparam logic signed [33:0] RND_SH = (34'sd1 <<< SH) >>> 1;
  localparam logic [5:0] AX_ITERS = 6'(F + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_M, S_SQ_A, S_SQRT, S_CMP, S_PH_M, S_PH_I, S_PH_E, S_PH_Q,
    S_PH_R, S_PH_C, S_AX_I, S_AX_D, S_CR_I, S_CR, S_FIX, S_RV_M, S_RV_A,
    S_HM_M, S_HM_A, S_OUT
  } state_t;

  state_t state_r;
  logic [30:0] thr_r;
  logic [31:0] abs_r [3];
  logic [2:0]  neg_r;
  logic [29:0] dt_r;
  logic [4:0]  cnt_r;
  logic [5:0]  iter_r;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [31:0] mag_r;
  logic [39:0] dv_rem_r, dv_den_r, dv_num_r, dv_quo_r;
  logic [52:0] pd_x_r;
  logic [25:0] pd_num_r;
  logic [26:0] pd_q_r;
  logic [27:0] pd_r_r;
  logic [31:0] ph_r;
  logic signed [31:0] axis_r [3];
  logic flip_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [31:0] s_r;
  logic signed [31:0] rot_r [4];
  logic signed [31:0] quat_r [4];
  logic signed [31:0] nq_r [4];
  logic upd_r;

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  logic [1:0] hm_o, hm_t;
  assign hm_o = cnt_r[3:2];
  assign hm_t = cnt_r[1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_M: begin
        mul_a = {1'b0, abs_r[cnt_r[1:0]]};
        mul_b = {1'b0, abs_r[cnt_r[1:0]]};
      end
      S_PH_M: begin
        mul_a = {1'b0, mag_r};
        mul_b = {3'b000, dt_r};
      end
      S_PH_E: begin
        mul_a = {1'b0, pd_x_r[52:21]};
        mul_b = {1'b0, PH_RECIP};
      end
      S_PH_Q: begin
        mul_a = {6'd0, prod_r[63:37]};
        mul_b = {6'd0, PH_DIV};
      end
      S_RV_M: begin
        mul_a = 33'(axis_r[cnt_r[1:0]]);
        mul_b = 33'(s_r);
      end
      S_HM_M: begin
        mul_a = 33'(quat_r[hm_t]);
        mul_b = 33'(rot_r[hm_o ^ hm_t]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root step
  logic [63:0] sq_try;
  logic        sq_ge;
  assign sq_try = sq_res_r + sq_bit_r;
  assign sq_ge  = sq_v_r >= sq_try;

  // restoring divider step
  logic [40:0] dv_t;
  logic        dv_ge;
  logic [39:0] dv_rem_nxt;
  assign dv_t  = {dv_rem_r, dv_num_r[39]};
  assign dv_ge = dv_t >= {1'b0, dv_den_r};
  assign dv_rem_nxt = dv_ge ? 40'(dv_t - {1'b0, dv_den_r}) : dv_t[39:0];

  // phase digit correction: the estimate is low by at most one
  logic        pd_ge;
  logic [26:0] pd_digit;
  logic [26:0] pd_rem;
  assign pd_ge    = pd_r_r >= {1'b0, PH_DIV};
  assign pd_digit = pd_ge ? (pd_q_r + 27'd1) : pd_q_r;
  assign pd_rem   = pd_ge ? 27'(pd_r_r - {1'b0, PH_DIV}) : pd_r_r[26:0];

  // axis division source: roll, pitch, yaw
  logic [1:0]  ax_src;
  logic [31:0] ax_abs;
  logic signed [31:0] ax_q;
  always_comb begin
    case (cnt_r[1:0])
      2'd0: ax_src = 2'd1;
      2'd1: ax_src = 2'd0;
      default: ax_src = 2'd2;
    endcase
  end
  assign ax_abs = abs_r[ax_src];
  assign ax_q = {{(31 - F){1'b0}}, dv_quo_r[F:0]};

  // cordic fold and step
  logic [31:0] ph_off;
  logic        cr_flip;
  logic [31:0] ph_fold;
  logic signed [33:0] cr_xs, cr_ys;
  assign ph_off  = ph_r + 32'h4000_0000;
  assign cr_flip = ph_off[31];
  assign ph_fold = cr_flip ? (ph_r ^ 32'h8000_0000) : ph_r;
  assign cr_xs = x_r >>> iter_r[4:0];
  assign cr_ys = y_r >>> iter_r[4:0];

  // cordic output fix: unfold, clamp, round to the quaternion format
  logic signed [33:0] xf, yf, xc, yc, cq, sq;
  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xc = (xf > Q30_ONE) ? Q30_ONE : ((xf < -Q30_ONE) ? -Q30_ONE : xf);
    yc = (yf > Q30_ONE) ? Q30_ONE : ((yf < -Q30_ONE) ? -Q30_ONE : yf);
    cq = (xc + RND_SH) >>> SH;
    sq = (yc + RND_SH) >>> SH;
  end

  // rounding and accumulation
  logic signed [65:0] rv_rnd, hm_sum, hm_rnd, hm_sat;
  assign rv_rnd = (prod_r + RND_F) >>> F;
  assign hm_sum = ham_neg(hm_o, hm_t) ? (acc_r - prod_r) : (acc_r + prod_r);
  assign hm_rnd = (hm_sum + RND_F) >>> F;
  assign hm_sat = (hm_rnd > ONE66) ? ONE66 : ((hm_rnd < -ONE66) ? -ONE66 : hm_rnd);

  // handshake and result ports
  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign out_quat_w  = quat_r[0];
  assign out_quat_x  = quat_r[1];
  assign out_quat_y  = quat_r[2];
  assign out_quat_z  = quat_r[3];
  assign out_updated = upd_r;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      thr_r     <= 31'd19661;
      quat_r[0] <= ONE;
      quat_r[1] <= '0;
      quat_r[2] <= '0;
      quat_r[3] <= '0;
      upd_r     <= 1'b0;
      cnt_r     <= '0;
      iter_r    <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            abs_r[0] <= in_rate_pitch[31] ? 32'(-in_rate_pitch) : in_rate_pitch;
            abs_r[1] <= in_rate_roll[31] ? 32'(-in_rate_roll) : in_rate_roll;
            abs_r[2] <= in_rate_yaw[31] ? 32'(-in_rate_yaw) : in_rate_yaw;
            neg_r    <= {in_rate_yaw[31], in_rate_roll[31], in_rate_pitch[31]};
            dt_r     <= in_interval_ns;
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= S_SQ_M;
          end
        end
        S_SQ_M: state_r <= S_SQ_A;
        S_SQ_A: begin
          acc_r <= acc_r + prod_r;
          if (cnt_r == 5'd2) begin
            sq_v_r   <= 64'(acc_r + prod_r);
            sq_res_r <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            iter_r   <= 6'd32;
            state_r  <= S_SQRT;
          end else begin
            cnt_r   <= cnt_r + 5'd1;
            state_r <= S_SQ_M;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_r   <= sq_v_r - sq_try;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          iter_r   <= iter_r - 6'd1;
          if (iter_r == 6'd1) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          mag_r <= sq_res_r[31:0];
          if (sq_res_r[31:0] < {1'b0, thr_r}) begin
            upd_r   <= 1'b0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_PH_M;
          end
        end
        S_PH_M: state_r <= S_PH_I;
        // phase = (prod * 8) / PH_DIV as two base 2^26 digits
        S_PH_I: begin
          pd_x_r   <= {14'd0, prod_r[61:23]};
          pd_num_r <= {prod_r[22:0], 3'b000};
          iter_r   <= 6'd1;
          state_r  <= S_PH_E;
        end
        S_PH_E: state_r <= S_PH_Q;
        S_PH_Q: begin
          pd_q_r  <= prod_r[63:37];
          state_r <= S_PH_R;
        end
        S_PH_R: begin
          pd_r_r  <= 28'(pd_x_r - prod_r[52:0]);
          state_r <= S_PH_C;
        end
        S_PH_C: begin
          if (iter_r == 6'd1) begin
            ph_r    <= {pd_digit[5:0], 26'd0};
            pd_x_r  <= {pd_rem, pd_num_r};
            iter_r  <= 6'd0;
            state_r <= S_PH_E;
          end else begin
            ph_r  <= {ph_r[31:26], pd_digit[25:0]};
            cnt_r <= '0;
            if (mag_r == 32'd0) begin
              axis_r[0] <= '0;
              axis_r[1] <= '0;
              axis_r[2] <= '0;
              state_r   <= S_CR_I;
            end else begin
              state_r <= S_AX_I;
            end
          end
        end
        S_AX_I: begin
          dv_rem_r <= {9'd0, ax_abs[31:1]};
          dv_num_r <= {ax_abs[0], 39'd0};
          dv_den_r <= {8'd0, mag_r};
          dv_quo_r <= '0;
          iter_r   <= AX_ITERS;
          state_r  <= S_AX_D;
        end
        S_AX_D: begin
          dv_rem_r <= dv_rem_nxt;
          dv_num_r <= dv_num_r << 1;
          dv_quo_r <= {dv_quo_r[38:0], dv_ge};
          iter_r   <= iter_r - 6'd1;
          if (iter_r == 6'd0) begin
            axis_r[cnt_r[1:0]] <= neg_r[ax_src] ? -ax_q : ax_q;
            if (cnt_r == 5'd2) begin
              state_r <= S_CR_I;
            end else begin
              cnt_r   <= cnt_r + 5'd1;
              state_r <= S_AX_I;
            end
          end
        end
        S_CR_I: begin
          flip_r  <= cr_flip;
          x_r     <= CORDIC_X0;
          y_r     <= '0;
          z_r     <= 34'(signed'(ph_fold));
          iter_r  <= '0;
          state_r <= S_CR;
        end
        S_CR: begin
          if (!z_r[33]) begin
            x_r <= x_r - cr_ys;
            y_r <= y_r + cr_xs;
            z_r <= z_r - atan_lut(iter_r[4:0]);
          end else begin
            x_r <= x_r + cr_ys;
            y_r <= y_r - cr_xs;
            z_r <= z_r + atan_lut(iter_r[4:0]);
          end
          iter_r <= iter_r + 6'd1;
          if (iter_r == 6'(CORDIC_STEPS - 1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          rot_r[0] <= 32'(cq);
          s_r      <= 32'(sq);
          cnt_r    <= '0;
          state_r  <= S_RV_M;
        end
        S_RV_M: state_r <= S_RV_A;
        S_RV_A: begin
          rot_r[cnt_r[1:0] + 2'd1] <= 32'(rv_rnd);
          if (cnt_r == 5'd2) begin
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= S_HM_M;
          end else begin
            cnt_r   <= cnt_r + 5'd1;
            state_r <= S_RV_M;
          end
        end
        S_HM_M: state_r <= S_HM_A;
        S_HM_A: begin
          if (hm_t == 2'd3) begin
            nq_r[hm_o] <= 32'(hm_sat);
            acc_r      <= '0;
          end else begin
            acc_r <= hm_sum;
          end
          if (cnt_r == 5'd15) begin
            quat_r[0] <= nq_r[0];
            quat_r[1] <= nq_r[1];
            quat_r[2] <= nq_r[2];
            quat_r[3] <= 32'(hm_sat);
            upd_r     <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            cnt_r   <= cnt_r + 5'd1;
            state_r <= S_HM_M;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input ready while result pending");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second transaction taken");
  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= ONE && out_quat_w >= -ONE))
    else $error("w out of range");
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_x <= ONE && out_quat_x >= -ONE))
    else $error("x out of range");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for the gyro quaternion integrator: table-driven directed rows, threshold corner cases, then random rates
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 30;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint HALF_TURN = 64'd720000000000;
  localparam longint CYCLE_LIMIT = 64'd2000000;
  localparam int SETTLE_CYCLES = 300;

  localparam logic [31:0] RATE_MAX = 32'h7fffffff;
  localparam logic [31:0] RATE_MIN = 32'h80000000;
  localparam logic [29:0] DT_MAX = 30'h3fffffff;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               updated;
  } orient_t;

  typedef struct {
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [31:0] yaw;
    logic [29:0] dt;
    bit          typed;
    orient_t     typed_res;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_rate_pitch = '0;
  logic signed [31:0] in_rate_roll = '0;
  logic signed [31:0] in_rate_yaw = '0;
  logic [29:0] in_interval_ns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_updated;

  gyro_quaternion_integrator u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rate_pitch(in_rate_pitch), .in_rate_roll(in_rate_roll),
    .in_rate_yaw(in_rate_yaw), .in_interval_ns(in_interval_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_updated(out_updated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint orient_q[4];
  longint threshold;
  orient_t expected_orient[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_half_up(longint v, int n);
    if (n == 0) return v;
    return (v + (64'sd1 << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_one(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res[31:0]);
  endfunction

  function automatic longint unit_axis(longint rate, longint mag);
    logic [63:0] a, q;
    a = rate < 0 ? -rate : rate;
    q = (a << FRAC) / mag;
    return rate < 0 ? -longint'(q) : longint'(q);
  endfunction

  // cos and sin of a binary half angle, 2^32 per turn
  task automatic sin_cos(input logic [31:0] ph, output longint c, output longint s);
    bit flip;
    longint x, y, z, nx;
    logic [31:0] ph_sum;
    ph_sum = ph + 32'h40000000;
    flip = ph_sum[31];
    if (flip) ph[31] = ~ph[31];
    z = longint'(signed'(ph));
    x = gqi_pkg::CORDIC_X0;
    y = 0;
    for (int i = 0; i < gqi_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - longint'(gqi_pkg::atan_lut(5'(i)));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + longint'(gqi_pkg::atan_lut(5'(i)));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_one(x, 64'sd1 << 30);
    s = clamp_one(y, 64'sd1 << 30);
  endtask

  // rotate the orientation by one gyro sample
  task automatic integrate_rates(input sample_t smp, output orient_t res);
    longint rp, rr, ry, mag, c, s, rw, rx, rya, rz, ax, ayx, az;
    longint qw, qx, qy, qz;
    logic [63:0] sq, prod, quo, rem;
    logic [31:0] ph;
    rp = longint'(signed'(smp.pitch));
    rr = longint'(signed'(smp.roll));
    ry = longint'(signed'(smp.yaw));
    sq = rp * rp + rr * rr + ry * ry;
    mag = int_sqrt(sq);
    res.updated = 1'b0;
    if (mag >= threshold) begin
      qw = orient_q[0]; qx = orient_q[1]; qy = orient_q[2]; qz = orient_q[3];
      prod = mag * smp.dt;
      quo = prod / HALF_TURN;
      rem = prod % HALF_TURN;
      ph = 32'((quo << 16) + ((rem << 16) / HALF_TURN));
      ax = 0; ayx = 0; az = 0;
      if (mag != 0) begin
        ax = unit_axis(rr, mag);
        ayx = unit_axis(rp, mag);
        az = unit_axis(ry, mag);
      end
      sin_cos(ph, c, s);
      rw = round_half_up(c, 30 - FRAC);
      s = round_half_up(s, 30 - FRAC);
      rx = round_half_up(ax * s, FRAC);
      rya = round_half_up(ayx * s, FRAC);
      rz = round_half_up(az * s, FRAC);
      orient_q[0] = clamp_one(round_half_up(qw*rw - qx*rx - qy*rya - qz*rz, FRAC), ONE);
      orient_q[1] = clamp_one(round_half_up(qw*rx + qx*rw + qy*rz - qz*rya, FRAC), ONE);
      orient_q[2] = clamp_one(round_half_up(qw*rya - qx*rz + qy*rw + qz*rx, FRAC), ONE);
      orient_q[3] = clamp_one(round_half_up(qw*rz + qx*rya - qy*rx + qz*rw, FRAC), ONE);
      res.updated = 1'b1;
    end
    res.w = orient_q[0][31:0];
    res.x = orient_q[1][31:0];
    res.y = orient_q[2][31:0];
    res.z = orient_q[3][31:0];
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[gyro_quaternion_integrator] ERROR");
      $finish;
    end
  end

  // result side: random stall, check at the rising edge
  always @(posedge clk) begin
    orient_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_updated};
      if (expected_orient.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = expected_orient.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_threshold(input logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  task automatic wait_drained();
    while (expected_orient.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // drive one sample transaction and queue its prediction
  task automatic send_sample(input sample_t smp);
    orient_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_rate_pitch <= smp.pitch;
    in_rate_roll <= smp.roll;
    in_rate_yaw <= smp.yaw;
    in_interval_ns <= smp.dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    integrate_rates(smp, res);
    if (smp.typed && res !== smp.typed_res) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", smp.typed_res, res);
    end
    expected_orient.push_back(res);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_rate(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(2000000) - 1000000);
      default: return 32'($urandom_range(40000) - 20000);
    endcase
  endfunction

  sample_t dir_table[$];
  sample_t smp;
  orient_t id_still;

  initial begin
    id_still = '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 1'b0};
    // directed rows: below threshold, zero interval, extremes, wraps
    dir_table.push_back('{32'd0, 32'd0, 32'd0, 30'd5000, 1'b1, id_still});
    dir_table.push_back('{32'd100, 32'd100, 32'd100, DT_MAX, 1'b1, id_still});
    dir_table.push_back('{32'd65536, 32'd0, 32'd0, 30'd0, 1'b0, id_still});
    dir_table.push_back('{32'd0, 32'd6553600, 32'd0, 30'd1000000, 1'b0, id_still});
    dir_table.push_back('{32'd0, 32'd0, RATE_MAX, 30'd1000000, 1'b0, id_still});
    dir_table.push_back('{RATE_MIN, RATE_MIN, RATE_MIN, DT_MAX, 1'b0, id_still});
    dir_table.push_back('{RATE_MAX, RATE_MAX, RATE_MAX, DT_MAX, 1'b0, id_still});
    dir_table.push_back('{RATE_MIN, 32'd0, RATE_MAX, 30'd12345678, 1'b0, id_still});
    dir_table.push_back('{32'hffff0000, 32'd65536, 32'hfffe0000, 30'd2000000, 1'b0, id_still});
    dir_table.push_back('{32'd19660, 32'd0, 32'd0, 30'd1000, 1'b0, id_still});
    dir_table.push_back('{32'd19661, 32'd0, 32'd0, 30'd1000, 1'b0, id_still});
    dir_table.push_back('{32'd11796480, 32'd0, 32'd0, 30'd1000000000, 1'b0, id_still});
    threshold = 19661;
    orient_q = '{ONE, 0, 0, 0};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) send_sample(dir_table[i]);
    wait_drained();

    // zero threshold: zero magnitude still rotates
    write_threshold(31'd0);
    send_sample('{32'd0, 32'd0, 32'd0, 30'd0, 1'b0, id_still});
    send_sample('{32'd0, 32'd0, 32'd0, DT_MAX, 1'b0, id_still});
    wait_drained();
    write_threshold(31'h7fffffff);
    send_sample('{RATE_MAX, RATE_MAX, 32'd0, DT_MAX, 1'b0, id_still});
    send_sample('{RATE_MIN, RATE_MIN, RATE_MIN, DT_MAX, 1'b0, id_still});
    wait_drained();

    // random phases with changing idle patterns and thresholds
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 61 : 0;
      recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 22 : 0;
      write_threshold(ph == 0 ? 31'd19661 : ph == 1 ? 31'($urandom_range(3000000)) : 31'd1);
      for (int n = 0; n < 200; n++) begin
        smp.pitch = rand_rate($urandom_range(2));
        smp.roll = rand_rate($urandom_range(2));
        smp.yaw = rand_rate($urandom_range(2));
        smp.dt = ($urandom_range(3) == 0) ? 30'($urandom()) : 30'($urandom_range(20000000));
        smp.typed = 1'b0;
        smp.typed_res = id_still;
        send_sample(smp);
        if (n == 100) while (expected_orient.size() != 0) @(negedge clk);
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_orient.size() == 0) begin
      $display("[gyro_quaternion_integrator] OK");
    end else begin
      $display("[gyro_quaternion_integrator] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
